@@ hw/rtl/dsg_pkg.sv @@
`default_nettype none

package dsg_pkg;

  localparam int IDX_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_CFG_W   = 11;
  localparam int IN_POS_W    = 32;
  localparam int OUT_W       = 48;
  localparam int Q_W         = 65;
  localparam int DIV_SHIFT   = 64;
  localparam int K_W         = 64;
  localparam int SCALE_SHIFT = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTICLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_MASS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] GRAV_CONST_RESET    = 32'd2818513;
  localparam logic [CFG_DATA_W-1:0] PARTICLE_MASS_RESET = 32'd65536;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRAP,
    ST_KA_GO,
    ST_KA_WAIT,
    ST_KB_GO,
    ST_KB_WAIT,
    ST_RD_SELF,
    ST_LAT_SELF,
    ST_J_CHECK,
    ST_J_LAT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_S_CHECK,
    ST_SQRT_WAIT,
    ST_DEN_GO,
    ST_DEN_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_J_NEXT,
    ST_SC_GO,
    ST_SC_WAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/direct_sum_gravity_accel_core.sv @@
`default_nettype none

// Channel | Ports                                   | Beat
// in      | in_valid/in_ready, in_func..in_pos_z    | load or query
// out     | out_valid/out_ready, out_particle..     | one result per query
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data| register write
//
// A load waits in ST_WRAP, which subtracts MAX_PARTICLES from the index until it is in range, then writes the store.
// A query runs the one shared shift-add multiplier, the square root unit and the
// bit-serial divider in turn for each other particle (it skips itself), and ends
// with the three scalings.
// Reset is synchronous; the position store is not cleared.
// A finished result waits in the output register; loads are still taken meanwhile.
module direct_sum_gravity_accel_core #(
  parameter int MAX_PARTICLES = 1024,
  parameter int POS_WIDTH     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [9:0]  in_index,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_particle,
  output logic signed [47:0] out_accel_x,
  output logic signed [47:0] out_accel_y,
  output logic signed [47:0] out_accel_z,
  output logic             out_saturated,
  output logic             out_coincident,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW     = $clog2(MAX_PARTICLES);
  localparam int JW     = $clog2(MAX_PARTICLES + 1);
  localparam int PW     = POS_WIDTH;
  localparam int D_W    = PW + 1;
  localparam int S_W    = 2 * PW + 2;
  localparam int R_W    = PW + 1;
  localparam int DEN_W  = S_W + R_W;
  localparam int NUM_W  = D_W + dsg_pkg::DIV_SHIFT;
  localparam int ACC_W  = dsg_pkg::Q_W + $clog2(MAX_PARTICLES) + 1;
  localparam int SMA_W  = (S_W > dsg_pkg::K_W) ? S_W : dsg_pkg::K_W;
  localparam int SMB_W  = ACC_W;
  localparam int P_W    = SMA_W + SMB_W;
  localparam int LEN_W  = $clog2(SMB_W + 1);
  localparam int OW     = dsg_pkg::OUT_W;
  localparam int SH     = dsg_pkg::SCALE_SHIFT;
  localparam int CW     = dsg_pkg::CFG_DATA_W;

  // configuration
  logic [dsg_pkg::NUM_CFG_W-1:0] num_r;
  logic [CW-1:0]                 grav_r;
  logic [CW-1:0]                 mass_r;

  dsg_pkg::state_t state_r, state_nxt;

  logic                      func_r;
  logic [dsg_pkg::IDX_W-1:0] idx_r;
  logic [PW-1:0]             wx_r, wy_r, wz_r;
  logic [dsg_pkg::K_W-1:0]   gm_r, k_r;
  logic [3*PW-1:0]           pi_r;
  logic [JW-1:0]             j_r, n_r;
  logic [1:0]                c_r;
  logic                      d_neg_r [3];
  logic [D_W-1:0]            mag_r [3];
  logic [S_W-1:0]            s_r;
  logic [R_W-1:0]            r_r;
  logic [DEN_W-1:0]          den_r;
  logic signed [ACC_W-1:0]   acc_r [3];
  logic [OW-1:0]             res_r [3];
  logic                      sc_neg_r;
  logic                      sat_r, coinc_r;
  logic                      out_valid_r;

  // memory and unit hookup
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [3*PW-1:0]     ram_rdata;
  logic [AW-1:0]       idx_addr;
  logic                smul_start, sqrt_start, div_start;
  logic [SMA_W-1:0]    smul_a;
  logic [SMB_W-1:0]    smul_b;
  logic [LEN_W-1:0]    smul_len;
  logic [P_W-1:0]      smul_p;
  logic [R_W-1:0]      sqrt_root;
  logic [NUM_W-1:0]    div_quo;
  dsg_pkg::unit_stat_t smul_stat, sqrt_stat, div_stat;

  logic                    wrap_need;
  logic                    last_c;
  logic signed [D_W-1:0]   diff [3];
  logic signed [ACC_W-1:0] acc_sel;
  logic [ACC_W-1:0]        acc_abs;
  logic [ACC_W-1:0]        q_ext;
  logic                    sc_big, sc_h47, sc_low_zero, sc_sat;
  logic [OW-1:0]           sc_mag, sc_val;

  assign idx_addr  = AW'(idx_r);
  assign wrap_need = 32'(idx_r) >= 32'(MAX_PARTICLES);
  assign last_c    = c_r == 2'd2;
  assign in_ready  = state_r == dsg_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({pi_r[k*PW + PW - 1], pi_r[k*PW +: PW]})
              - $signed({ram_rdata[k*PW + PW - 1], ram_rdata[k*PW +: PW]});
    end
  end

  assign acc_sel = acc_r[c_r];
  assign acc_abs = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
  assign q_ext   = ACC_W'(div_quo[dsg_pkg::Q_W-1:0]);

  // clip K*|A| >> 24 to the signed 48-bit range
  assign sc_big      = |smul_p[P_W-1:SH+OW];
  assign sc_h47      = smul_p[SH+OW-1];
  assign sc_low_zero = smul_p[SH+OW-2:SH] == '0;
  assign sc_mag      = smul_p[SH+OW-1:SH];
  always_comb begin
    if (sc_neg_r) begin
      sc_sat = sc_big | (sc_h47 & !sc_low_zero);
      sc_val = sc_sat ? {1'b1, {(OW-1){1'b0}}} : OW'(-sc_mag);
    end else begin
      sc_sat = sc_big | sc_h47;
      sc_val = sc_sat ? {1'b0, {(OW-1){1'b1}}} : sc_mag;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r  <= '0;
      grav_r <= dsg_pkg::GRAV_CONST_RESET;
      mass_r <= dsg_pkg::PARTICLE_MASS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dsg_pkg::CFG_NUM_PARTICLES: num_r  <= cfg_data[dsg_pkg::NUM_CFG_W-1:0];
        dsg_pkg::CFG_GRAV_CONST:    grav_r <= cfg_data;
        dsg_pkg::CFG_PARTICLE_MASS: mass_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsg_pkg::ST_IDLE:      if (in_valid) state_nxt = dsg_pkg::ST_WRAP;
      dsg_pkg::ST_WRAP: begin
        if (!wrap_need) begin
          state_nxt = (func_r == dsg_pkg::FUNC_LOAD) ? dsg_pkg::ST_IDLE : dsg_pkg::ST_KA_GO;
        end
      end
      dsg_pkg::ST_KA_GO:     state_nxt = dsg_pkg::ST_KA_WAIT;
      dsg_pkg::ST_KA_WAIT:   if (smul_stat.done) state_nxt = dsg_pkg::ST_KB_GO;
      dsg_pkg::ST_KB_GO:     state_nxt = dsg_pkg::ST_KB_WAIT;
      dsg_pkg::ST_KB_WAIT:   if (smul_stat.done) state_nxt = dsg_pkg::ST_RD_SELF;
      dsg_pkg::ST_RD_SELF:   state_nxt = dsg_pkg::ST_LAT_SELF;
      dsg_pkg::ST_LAT_SELF:  state_nxt = dsg_pkg::ST_J_CHECK;
      dsg_pkg::ST_J_CHECK: begin
        if (j_r >= n_r) begin
          state_nxt = dsg_pkg::ST_SC_GO;
        end else if (j_r != JW'(idx_addr)) begin
          state_nxt = dsg_pkg::ST_J_LAT;
        end
      end
      dsg_pkg::ST_J_LAT:     state_nxt = dsg_pkg::ST_SQ_GO;
      dsg_pkg::ST_SQ_GO:     state_nxt = dsg_pkg::ST_SQ_WAIT;
      dsg_pkg::ST_SQ_WAIT: begin
        if (smul_stat.done) state_nxt = last_c ? dsg_pkg::ST_S_CHECK : dsg_pkg::ST_SQ_GO;
      end
      dsg_pkg::ST_S_CHECK: begin
        state_nxt = (s_r == '0) ? dsg_pkg::ST_J_NEXT : dsg_pkg::ST_SQRT_WAIT;
      end
      dsg_pkg::ST_SQRT_WAIT: if (sqrt_stat.done) state_nxt = dsg_pkg::ST_DEN_GO;
      dsg_pkg::ST_DEN_GO:    state_nxt = dsg_pkg::ST_DEN_WAIT;
      dsg_pkg::ST_DEN_WAIT:  if (smul_stat.done) state_nxt = dsg_pkg::ST_DIV_GO;
      dsg_pkg::ST_DIV_GO: begin
        if (mag_r[c_r] != '0) begin
          state_nxt = dsg_pkg::ST_DIV_WAIT;
        end else if (last_c) begin
          state_nxt = dsg_pkg::ST_J_NEXT;
        end
      end
      dsg_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = last_c ? dsg_pkg::ST_J_NEXT : dsg_pkg::ST_DIV_GO;
      end
      dsg_pkg::ST_J_NEXT:    state_nxt = dsg_pkg::ST_J_CHECK;
      dsg_pkg::ST_SC_GO:     state_nxt = dsg_pkg::ST_SC_WAIT;
      dsg_pkg::ST_SC_WAIT: begin
        if (smul_stat.done) state_nxt = last_c ? dsg_pkg::ST_OUT : dsg_pkg::ST_SC_GO;
      end
      dsg_pkg::ST_OUT:       if (!out_valid_r || out_ready) state_nxt = dsg_pkg::ST_IDLE;
      default:               state_nxt = dsg_pkg::ST_IDLE;
    endcase
  end

  // unit and memory controls
  always_comb begin
    ram_we     = 1'b0;
    ram_raddr  = AW'(j_r);
    smul_start = 1'b0;
    smul_a     = '0;
    smul_b     = '0;
    smul_len   = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      dsg_pkg::ST_WRAP: ram_we = !wrap_need && func_r == dsg_pkg::FUNC_LOAD;
      dsg_pkg::ST_KA_GO: begin
        smul_start = 1'b1;
        smul_a     = SMA_W'(grav_r);
        smul_b     = {mass_r, {(SMB_W-CW){1'b0}}};
        smul_len   = LEN_W'(CW);
      end
      dsg_pkg::ST_KB_GO: begin
        smul_start = 1'b1;
        smul_a     = SMA_W'(gm_r);
        smul_b     = {mass_r, {(SMB_W-CW){1'b0}}};
        smul_len   = LEN_W'(CW);
      end
      dsg_pkg::ST_RD_SELF: ram_raddr = idx_addr;
      dsg_pkg::ST_SQ_GO: begin
        smul_start = 1'b1;
        smul_a     = SMA_W'(mag_r[c_r]);
        smul_b     = {mag_r[c_r], {(SMB_W-D_W){1'b0}}};
        smul_len   = LEN_W'(D_W);
      end
      dsg_pkg::ST_S_CHECK: sqrt_start = s_r != '0;
      dsg_pkg::ST_DEN_GO: begin
        smul_start = 1'b1;
        smul_a     = SMA_W'(s_r);
        smul_b     = {r_r, {(SMB_W-R_W){1'b0}}};
        smul_len   = LEN_W'(R_W);
      end
      dsg_pkg::ST_DIV_GO: div_start = mag_r[c_r] != '0;
      dsg_pkg::ST_SC_GO: begin
        smul_start = 1'b1;
        smul_a     = SMA_W'(k_r);
        smul_b     = acc_abs;
        smul_len   = LEN_W'(ACC_W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dsg_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      dsg_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_r <= in_func;
          idx_r  <= in_index;
          wx_r   <= in_pos_x[PW-1:0];
          wy_r   <= in_pos_y[PW-1:0];
          wz_r   <= in_pos_z[PW-1:0];
        end
      end
      dsg_pkg::ST_WRAP: begin
        if (wrap_need) begin
          idx_r <= dsg_pkg::IDX_W'(32'(idx_r) - 32'(MAX_PARTICLES));
        end
      end
      dsg_pkg::ST_KA_WAIT: if (smul_stat.done) gm_r <= smul_p[dsg_pkg::K_W-1:0];
      dsg_pkg::ST_KB_WAIT: if (smul_stat.done) k_r <= smul_p[dsg_pkg::K_W+CW-1:CW];
      dsg_pkg::ST_LAT_SELF: begin
        pi_r    <= ram_rdata;
        j_r     <= '0;
        n_r     <= (32'(num_r) > 32'(MAX_PARTICLES)) ? JW'(MAX_PARTICLES) : JW'(num_r);
        sat_r   <= 1'b0;
        coinc_r <= 1'b0;
        for (int k = 0; k < 3; k++) acc_r[k] <= '0;
      end
      dsg_pkg::ST_J_CHECK: begin
        if (j_r >= n_r) begin
          c_r <= 2'd0;
        end else if (j_r == JW'(idx_addr)) begin
          j_r <= j_r + JW'(1);   // skip self
        end
      end
      dsg_pkg::ST_J_LAT: begin
        for (int k = 0; k < 3; k++) begin
          d_neg_r[k] <= diff[k][D_W-1];
          mag_r[k]   <= diff[k][D_W-1] ? D_W'(-diff[k]) : D_W'(diff[k]);
        end
        s_r <= '0;
        c_r <= 2'd0;
      end
      dsg_pkg::ST_SQ_WAIT: begin
        if (smul_stat.done) begin
          s_r <= s_r + S_W'(smul_p);
          c_r <= last_c ? 2'd0 : c_r + 2'd1;
        end
      end
      dsg_pkg::ST_S_CHECK: if (s_r == '0) coinc_r <= 1'b1;
      dsg_pkg::ST_SQRT_WAIT: if (sqrt_stat.done) r_r <= sqrt_root;
      dsg_pkg::ST_DEN_WAIT: begin
        if (smul_stat.done) begin
          den_r <= smul_p[DEN_W-1:0];
          c_r   <= 2'd0;
        end
      end
      dsg_pkg::ST_DIV_GO: if (mag_r[c_r] == '0 && !last_c) c_r <= c_r + 2'd1;
      dsg_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          // negative offset pulls toward +, positive toward -
          acc_r[c_r] <= d_neg_r[c_r] ? acc_r[c_r] + $signed(q_ext)
                                     : acc_r[c_r] - $signed(q_ext);
          c_r <= last_c ? 2'd0 : c_r + 2'd1;
        end
      end
      dsg_pkg::ST_J_NEXT: j_r <= j_r + JW'(1);
      dsg_pkg::ST_SC_GO: sc_neg_r <= acc_sel[ACC_W-1];
      dsg_pkg::ST_SC_WAIT: begin
        if (smul_stat.done) begin
          res_r[c_r] <= sc_val;
          sat_r      <= sat_r | sc_sat;
          c_r        <= last_c ? 2'd0 : c_r + 2'd1;
        end
      end
      dsg_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_particle   <= idx_r;
          out_accel_x    <= res_r[0];
          out_accel_y    <= res_r[1];
          out_accel_z    <= res_r[2];
          out_saturated  <= sat_r;
          out_coincident <= coinc_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  dsg_ram #(
    .WIDTH (3 * PW),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_addr),
    .wdata ({wz_r, wy_r, wx_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dsg_smul #(
    .A_W (SMA_W),
    .B_W (SMB_W)
  ) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (smul_start),
    .a     (smul_a),
    .b     (smul_b),
    .len   (smul_len),
    .p     (smul_p),
    .stat  (smul_stat)
  );

  dsg_sqrt #(
    .R_W (R_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .s     (s_r),
    .root  (sqrt_root),
    .stat  (sqrt_stat)
  );

  dsg_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({mag_r[c_r], {dsg_pkg::DIV_SHIFT{1'b0}}}),
    .den   (den_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

`ifndef SYNTHESIS
  a_smul_free: assert property (@(posedge clk) disable iff (!rst_n)
    smul_start |-> !smul_stat.busy)
    else $error("multiplier restarted while busy");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (den_r != '0) && !div_stat.busy)
    else $error("divider started with zero divisor or while busy");

  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsg_pkg::ST_J_LAT) |-> (j_r < n_r) && (j_r != JW'(idx_addr)))
    else $error("pair index out of range or self");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == dsg_pkg::ST_OUT)
    else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/dsg_ram.sv @@
`default_nettype none

module dsg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/dsg_smul.sv @@
`default_nettype none

// Shift-add multiplier, multiplier operand taken MSB first and left aligned;
// len steps give a times the top len bits of b.
module dsg_smul #(
  parameter int A_W = 66,
  parameter int B_W = 76,
  localparam int P_W = A_W + B_W,
  localparam int LEN_W = $clog2(B_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  input  wire logic [LEN_W-1:0] len,
  output logic      [P_W-1:0]   p,
  output dsg_pkg::unit_stat_t   stat
);

  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [P_W-1:0]   p_r;
  logic [LEN_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= {p_r[P_W-2:0], 1'b0} + (b_r[B_W-1] ? P_W'(a_r) : '0);
      b_r <= {b_r[B_W-2:0], 1'b0};
    end
  end

  assign p         = p_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/dsg_sqrt.sv @@
`default_nettype none

// Integer square root, two radicand bits per step.
module dsg_sqrt #(
  parameter int R_W = 33,
  localparam int S_W = 2 * R_W,
  localparam int CNT_W = $clog2(R_W + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [S_W-1:0] s,
  output logic      [R_W-1:0] root,
  output dsg_pkg::unit_stat_t stat
);

  logic [S_W-1:0]   s_r;
  logic [R_W+1:0]   rem_r;
  logic [R_W-1:0]   root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [R_W+3:0]   rem_t;
  logic [R_W+3:0]   trial;
  logic             ge;

  assign rem_t = {rem_r, s_r[S_W-1 -: 2]};
  assign trial = (R_W + 4)'({root_r, 2'b01});
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(R_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r    <= s;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      s_r    <= {s_r[S_W-3:0], 2'b00};
      rem_r  <= ge ? (R_W + 2)'(rem_t - trial) : (R_W + 2)'(rem_t);
      root_r <= {root_r[R_W-2:0], ge};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/dsg_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module dsg_div #(
  parameter int NUM_W = 97,
  parameter int DEN_W = 99,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output dsg_pkg::unit_stat_t   stat
);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_t;
  logic             ge;

  assign rem_t = {rem_r, num_r[NUM_W-1]};
  assign ge    = rem_t >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? DEN_W'(rem_t - {1'b0, den_r}) : DEN_W'(rem_t);
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ dv/direct_sum_gravity_accel_core_test.sv @@
`default_nettype none

module direct_sum_gravity_accel_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SLOTS       = 1024;
  localparam int  CYCLE_LIMIT = 6000000;
  localparam int  ITEM_GOAL   = 580;
  localparam int  QUIET_FROM  = 30000;
  localparam int  QUIET_TO    = 90000;

  typedef struct {
    logic        func;
    logic [9:0]  index;
    logic [31:0] x, y, z;
  } particle_op_t;

  typedef struct {
    logic [9:0]  particle;
    logic [47:0] ax, ay, az;
    logic        sat;
    logic        coinc;
  } accel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = dsg_pkg::FUNC_LOAD;
  logic [9:0]  in_index = '0;
  logic [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_particle;
  logic [47:0] out_accel_x, out_accel_y, out_accel_z;
  logic        out_saturated, out_coincident;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = dsg_pkg::CFG_NUM_PARTICLES;
  logic [31:0] cfg_data = '0;

  direct_sum_gravity_accel_core dut (.*);

  always #6 clk = ~clk;

  // shadow of the block
  logic signed [31:0] pos_store [SLOTS][3];
  bit                 placed [SLOTS];
  logic [10:0]        num_particles = '0;
  logic [31:0]        grav_const = dsg_pkg::GRAV_CONST_RESET;
  logic [31:0]        particle_mass = dsg_pkg::PARTICLE_MASS_RESET;

  particle_op_t op_q[$];
  accel_t       accel_q[$];
  int           fail_count = 0;
  int           cycle = 0;
  int           results_seen = 0;
  int           items_made = 0;

  wire quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);

  function automatic logic [47:0] scale_clip(logic [127:0] a, logic [63:0] k,
                                             output bit clipped);
    logic [127:0] m;
    logic [191:0] p;
    logic [47:0]  mag;
    bit           big;
    bit           neg;
    neg = a[127];
    m = neg ? -a : a;
    p = 192'(k) * 192'(m);
    big = p >= (192'd1 << 72);
    mag = p[71:24];
    clipped = 1'b0;
    if (neg) begin
      if (big || mag > 48'h8000_0000_0000) begin
        clipped = 1'b1;
        mag = 48'h8000_0000_0000;
      end
      return -mag;
    end
    if (big || mag[47]) begin
      clipped = 1'b1;
      mag = 48'h7FFF_FFFF_FFFF;
    end
    return mag;
  endfunction

  function automatic accel_t gravity_of(logic [9:0] idx);
    accel_t       res;
    int           n;
    longint       d [3];
    longint unsigned mg [3];
    logic [127:0] acc [3];
    logic [127:0] s, den, q, c;
    logic [63:0]  r;
    logic [95:0]  gm2;
    bit           clip;
    res = '{default: '0};
    acc = '{default: '0};
    n = (num_particles > SLOTS) ? SLOTS : int'(num_particles);
    for (int j = 0; j < n; j++) begin
      if (j == idx) continue;
      s = '0;
      for (int c3 = 0; c3 < 3; c3++) begin
        d[c3] = longint'(pos_store[idx][c3]) - longint'(pos_store[j][c3]);
        mg[c3] = (d[c3] < 0) ? -d[c3] : d[c3];
        s += 128'(mg[c3]) * 128'(mg[c3]);
      end
      if (s == 0) begin
        res.coinc = 1'b1;
        continue;
      end
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = 128'(r | (64'd1 << b));
        if (c * c <= s) r = c[63:0];
      end
      den = s * 128'(r);
      for (int c3 = 0; c3 < 3; c3++) begin
        if (d[c3] == 0) continue;
        q = (128'(mg[c3]) << 64) / den;
        acc[c3] = (d[c3] < 0) ? acc[c3] + q : acc[c3] - q;
      end
    end
    gm2 = 96'(grav_const) * 96'(particle_mass) * 96'(particle_mass);
    res.particle = idx;
    res.ax = scale_clip(acc[0], gm2[95:32], clip);
    res.sat |= clip;
    res.ay = scale_clip(acc[1], gm2[95:32], clip);
    res.sat |= clip;
    res.az = scale_clip(acc[2], gm2[95:32], clip);
    res.sat |= clip;
    return res;
  endfunction

  function automatic int pending_queries();
    int cnt;
    cnt = 0;
    foreach (op_q[i]) begin
      if (op_q[i].func == dsg_pkg::FUNC_QUERY) cnt++;
    end
    return cnt;
  endfunction

  // sender
  always @(posedge clk) begin
    particle_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        if (in_func == dsg_pkg::FUNC_LOAD) begin
          pos_store[in_index] = '{in_pos_x, in_pos_y, in_pos_z};
          placed[in_index] = 1'b1;
        end else begin
          accel_q.push_back(gravity_of(in_index));
        end
      end
      if (op_q.size() > 0 && (quiet || $urandom_range(99) >= 32)) begin
        nxt = op_q.pop_front();
        in_valid <= 1'b1;
        in_func  <= nxt.func;
        in_index <= nxt.index;
        in_pos_x <= nxt.x;
        in_pos_y <= nxt.y;
        in_pos_z <= nxt.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  int hold_left = 0;
  bit held = 1'b0;

  always @(posedge clk) begin
    accel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (accel_q.size() == 0) begin
          $error("result beat with nothing expected: particle %0d", out_particle);
          fail_count++;
        end else begin
          want = accel_q.pop_front();
          if (out_particle !== want.particle) begin
            $error("particle: expected %0d, got %0d", want.particle, out_particle);
            fail_count++;
          end
          if (out_accel_x !== want.ax) begin
            $error("accel_x: expected %0d, got %0d", $signed(want.ax), $signed(out_accel_x));
            fail_count++;
          end
          if (out_accel_y !== want.ay) begin
            $error("accel_y: expected %0d, got %0d", $signed(want.ay), $signed(out_accel_y));
            fail_count++;
          end
          if (out_accel_z !== want.az) begin
            $error("accel_z: expected %0d, got %0d", $signed(want.az), $signed(out_accel_z));
            fail_count++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, out_saturated);
            fail_count++;
          end
          if (out_coincident !== want.coinc) begin
            $error("coincident: expected %0d, got %0d", want.coinc, out_coincident);
            fail_count++;
          end
        end
      end
      // long hold-off so the output register fills and the input backs up
      if (!held && results_seen >= 20 && pending_queries() >= 2) begin
        held = 1'b1;
        hold_left = 20000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dsg_pkg::CFG_NUM_PARTICLES: num_particles = data[10:0];
      dsg_pkg::CFG_GRAV_CONST:    grav_const = data;
      dsg_pkg::CFG_PARTICLE_MASS: particle_mass = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [10:0] n, logic [31:0] g, logic [31:0] m);
    write_reg(dsg_pkg::CFG_NUM_PARTICLES, 32'(n));
    write_reg(dsg_pkg::CFG_GRAV_CONST, g);
    write_reg(dsg_pkg::CFG_PARTICLE_MASS, m);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (op_q.size() > 0 || in_valid || accel_q.size() > 0) @(posedge clk);
    // a trailing load may still be in flight
    repeat (16) @(posedge clk);
  endtask

  task automatic load(logic [9:0] idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    op_q.push_back('{dsg_pkg::FUNC_LOAD, idx, x, y, z});
    items_made++;
  endtask

  task automatic query(logic [9:0] idx);
    op_q.push_back('{dsg_pkg::FUNC_QUERY, idx, $urandom, $urandom, $urandom});
    items_made++;
  endtask

  function automatic logic [31:0] coord(int spread);
    case (spread)
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  initial begin
    int n, spread, pick, qn;
    logic [9:0] extra;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register extremes; nothing is summed while these stand
    write_reg(dsg_pkg::CFG_NUM_PARTICLES, 32'd2047);
    write_reg(dsg_pkg::CFG_NUM_PARTICLES, 32'd1024);
    set_regs(11'd0, dsg_pkg::GRAV_CONST_RESET, dsg_pkg::PARTICLE_MASS_RESET);

    load(10'd0, 32'd0, 32'd0, 32'd0);
    load(10'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load(10'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load(10'd3, 32'd0, 32'd0, 32'd0);
    load(10'd1023, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
    load(10'd512, 32'd1, 32'hFFFF_FFFF, 32'd0);
    query(10'd0);
    drain();
    set_regs(11'd1, dsg_pkg::GRAV_CONST_RESET, dsg_pkg::PARTICLE_MASS_RESET);
    query(10'd0);
    query(10'd1023);
    drain();
    set_regs(11'd4, dsg_pkg::GRAV_CONST_RESET, dsg_pkg::PARTICLE_MASS_RESET);
    query(10'd0);
    query(10'd1);
    query(10'd2);
    query(10'd3);
    query(10'd512);
    query(10'd1023);
    drain();
    set_regs(11'd4, 32'd0, dsg_pkg::PARTICLE_MASS_RESET);
    query(10'd1);
    drain();
    set_regs(11'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    query(10'd512);
    query(10'd1023);
    drain();
    set_regs(11'd4, dsg_pkg::GRAV_CONST_RESET, 32'd0);
    query(10'd512);
    drain();

    while (items_made < ITEM_GOAL) begin
      n = (items_made > 300 && items_made < 330) ? 10 : $urandom_range(2, 6);
      case ($urandom_range(9))
        0:       set_regs(11'(n), $urandom, $urandom);
        1:       set_regs(11'(n), dsg_pkg::GRAV_CONST_RESET, dsg_pkg::PARTICLE_MASS_RESET);
        default: set_regs(11'(n), $urandom_range(1 << 22), $urandom_range(1 << 12, 1 << 18));
      endcase
      spread = $urandom_range(9) < 7 ? 2 : $urandom_range(1);
      for (int j = 0; j < n; j++)
        load(10'(j), coord(spread), coord(spread), coord(spread));
      extra = $urandom_range(SLOTS - 1);
      load(extra, coord(spread), coord(spread), coord(spread));
      // sometimes stack two particles on one point
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(n - 1);
        op_q.push_back(op_q[op_q.size() - 1]);
        op_q[op_q.size() - 1].index = 10'(pick);
        items_made++;
      end
      qn = 0;
      repeat (12) begin
        if ($urandom_range(9) < 6) begin
          query($urandom_range(4) == 0 ? extra : 10'($urandom_range(n - 1)));
          qn++;
        end else begin
          load($urandom_range(3) == 0 ? 10'($urandom_range(n - 1)) : 10'($urandom_range(SLOTS - 1)),
               coord(spread), coord(spread), coord(spread));
          // only slots below n or the extra slot are queried; mark nothing until accepted
        end
      end
      drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && accel_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/dsg_pkg.sv
hw/rtl/dsg_ram.sv
hw/rtl/dsg_smul.sv
hw/rtl/dsg_sqrt.sv
hw/rtl/dsg_div.sv
hw/rtl/direct_sum_gravity_accel_core.sv
dv/direct_sum_gravity_accel_core_test.sv
